@@ rtl/bls_pkg.sv @@
`timescale 1ns / 1ps

package bls_pkg;

    // store depth, the widths that follow from it and the value width
    localparam int DEPTH = 64;
    localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_DEL_HEAD = 2'd1,
        CMD_DEL_TAIL = 2'd2,
        CMD_SEARCH   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd                    command;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] found_position;
        logic [CNT_W-1:0] entry_count;
    } t_out;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic append;     // write value into the cell at the first free slot (slot == count)
        logic shift;      // entries move one cell toward the head
        logic load_hit;   // capture compare result against the value
        logic shift_hit;  // hit flags move one cell toward the head
    } t_cell_ctl;

endpackage

@@ rtl/bls_cell.sv @@
`timescale 1ns / 1ps

module bls_cell #(
    parameter int IDX = 0
) (
    input  logic                             i_clk,
    input  bls_pkg::t_cell_ctl               i_ctl,
    input  logic signed [bls_pkg::VAL_W-1:0] i_value,
    input  logic [bls_pkg::CNT_W-1:0]        i_count,
    input  logic signed [bls_pkg::VAL_W-1:0] i_next_entry,
    input  logic                             i_next_hit,
    output logic signed [bls_pkg::VAL_W-1:0] o_entry,
    output logic                             o_hit
);
    import bls_pkg::*;

    localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(IDX);

    logic signed [VAL_W-1:0] r_entry;
    logic                    r_hit;

    // entry payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_next_entry;
        end else if (i_ctl.append && (i_count == MY_SLOT)) begin
            r_entry <= i_value;
        end
    end

    // hit flag only live entries may match
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_hit) begin
            r_hit <= (r_entry == i_value) && (MY_SLOT < i_count);
        end else if (i_ctl.shift_hit) begin
            r_hit <= i_next_hit;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

@@ rtl/bls_ctrl.sv @@
`timescale 1ns / 1ps

module bls_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  bls_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output bls_pkg::t_out             o_out_data,
    input  logic                      i_head_hit,
    output bls_pkg::t_cell_ctl        o_ctl,
    output logic [bls_pkg::CNT_W-1:0] o_count
);
    import bls_pkg::*;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic             r_out_valid, n_out_valid;
    t_out             r_out,   n_out;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_ctl       = '0;
        o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
        accept      = i_in_valid && o_in_ready;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out.status         = STAT_OK;
                    n_out.found_position = '0;
                    unique case (i_in_data.command)
                        CMD_APPEND: begin
                            if (r_count == FULL_COUNT) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                o_ctl.append = 1'b1;
                                n_count      = r_count + 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                        CMD_DEL_HEAD, CMD_DEL_TAIL: begin
                            if (r_count == '0) begin
                                n_out.status = STAT_EMPTY;
                            end else begin
                                o_ctl.shift = (i_in_data.command == CMD_DEL_HEAD);
                                n_count     = r_count - 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                        CMD_SEARCH: begin
                            if (r_count == '0) begin
                                n_out.status = STAT_NOT_FOUND;
                                n_out_valid  = 1'b1;
                            end else begin
                                o_ctl.load_hit = 1'b1;
                                n_pos          = '0;
                                n_state        = S_SCAN;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                    n_out.entry_count = n_count;
                end
            end
            S_SCAN: begin
                n_out.entry_count    = r_count;
                n_out.found_position = '0;
                if (i_head_hit) begin
                    n_out.status         = STAT_OK;
                    n_out.found_position = r_pos;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end else if ((CNT_W'(r_pos) + 1'b1) == r_count) begin
                    n_out.status = STAT_NOT_FOUND;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_ctl.shift_hit = 1'b1;
                    n_pos           = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_count     = r_count;

endmodule

@@ rtl/bounded_list_with_search.sv @@
// append and deletes give their result in the cycle after the transaction is taken
// search loads the hit flags, then steps them until the head cell hits or every live position is checked
// one command in flight; a new one is taken as the result leaves the output register
// search time is set by the hit flags stepping one cell a cycle toward the head cell
// reset: synchronous active low, clears count, scan state and output valid; entries keep contents
`timescale 1ns / 1ps

module bounded_list_with_search (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bls_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bls_pkg::t_out o_out_data
);
    import bls_pkg::*;

    // chain wiring: cell k reads cell k+1, the last cell reads zeros
    logic signed [VAL_W-1:0] entry_chain [DEPTH+1];
    logic                    hit_chain   [DEPTH+1];

    t_cell_ctl        cell_ctl;
    logic [CNT_W-1:0] count;

    assign entry_chain[DEPTH] = '0;
    assign hit_chain[DEPTH]   = 1'b0;

    // command sequencing, entry count and the output register
    bls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_head_hit  (hit_chain[0]),
        .o_ctl       (cell_ctl),
        .o_count     (count)
    );

    // cell k always holds the entry at position k from the head,
    // so a head delete is a one-step shift of the whole chain
    // and a tail delete only lowers the count
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        bls_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_value      (i_in_data.value),
            .i_count      (count),
            .i_next_entry (entry_chain[k+1]),
            .i_next_hit   (hit_chain[k+1]),
            .o_entry      (entry_chain[k]),
            .o_hit        (hit_chain[k])
        );
    end

endmodule

@@ rtl/bls_checker.sv @@
`timescale 1ns / 1ps

module bls_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input bls_pkg::t_out o_out_data
);
    import bls_pkg::*;

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == STAT_EMPTY) |-> o_out_data.entry_count == '0)
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == STAT_FULL)
            |-> o_out_data.entry_count == CNT_W'(DEPTH))
        else $error("full status below depth");

    a_pos_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.found_position != '0)
            |-> (o_out_data.status == STAT_OK)
                && (CNT_W'(o_out_data.found_position) < o_out_data.entry_count))
        else $error("position reported without a live match");

endmodule

bind bounded_list_with_search bls_checker u_bls_checker (.*);
